// File: design/sdo_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package sdo_pkg;

    localparam int DEF_MAX_SEGMENTS = 64;
    localparam int DEF_COORD_BITS   = 32;
    localparam int FIELD_BITS       = 32;
    localparam int INDEX_BITS       = 6;
    localparam int DEPTH_BITS       = 64;

    localparam logic [DEPTH_BITS-1:0] TERM_LIMIT = 64'h2000_0000_0000_0000;

    typedef struct packed {
        logic                         first_of_set;
        logic signed [FIELD_BITS-1:0] left_x;
        logic signed [FIELD_BITS-1:0] left_depth;
        logic signed [FIELD_BITS-1:0] right_x;
        logic signed [FIELD_BITS-1:0] right_depth;
    } t_item;

    typedef struct packed {
        logic [INDEX_BITS-1:0] front_index;
        logic [INDEX_BITS-1:0] back_index;
        logic                  crossed;
        logic                  rejected;
        logic                  any_crossing;
        logic                  last;
    } t_result;

endpackage

`default_nettype wire

// File: design/sdo_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module sdo_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// File: design/sdo_interp.sv
`timescale 1ns / 1ps
`default_nettype none

module sdo_interp #(
    parameter int RUN_BITS = 33
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_start,
    input  wire logic signed [sdo_pkg::DEPTH_BITS-1:0] i_dz,
    input  wire logic signed [RUN_BITS-1:0]          i_run,
    input  wire logic signed [RUN_BITS-1:0]          i_span,
    output logic                                     o_done,
    output logic signed [sdo_pkg::DEPTH_BITS-1:0]    o_term
);
    import sdo_pkg::*;

    localparam int PW   = DEPTH_BITS + RUN_BITS;
    localparam int CNTW = $clog2(PW + 1);

    localparam logic [1:0] P_IDLE = 2'd0;
    localparam logic [1:0] P_MUL  = 2'd1;
    localparam logic [1:0] P_DIV  = 2'd2;
    localparam logic [1:0] P_FIN  = 2'd3;

    logic [1:0]            r_phase;
    logic [CNTW-1:0]       r_cnt;
    logic [PW-1:0]         r_acc;
    logic [PW-1:0]         r_mc;
    logic [RUN_BITS-1:0]   r_mr;
    logic [RUN_BITS-1:0]   r_den;
    logic [RUN_BITS-1:0]   r_rem;
    logic                  r_neg;
    logic                  r_done;
    logic signed [DEPTH_BITS-1:0] r_term;

    logic [DEPTH_BITS-1:0] mag_dz;
    logic [RUN_BITS-1:0]   mag_run;
    logic [RUN_BITS-1:0]   mag_span;
    logic [RUN_BITS:0]     shifted;
    logic                  fits;
    logic [DEPTH_BITS-1:0] q_sat;

    always_comb begin
        mag_dz   = i_dz[DEPTH_BITS-1] ? DEPTH_BITS'(-i_dz) : DEPTH_BITS'(i_dz);
        mag_run  = i_run[RUN_BITS-1] ? RUN_BITS'(-i_run) : RUN_BITS'(i_run);
        mag_span = i_span[RUN_BITS-1] ? RUN_BITS'(-i_span) : RUN_BITS'(i_span);
        shifted  = {r_rem, r_acc[PW-1]};
        fits     = shifted >= {1'b0, r_den};
        q_sat    = (r_acc > PW'(TERM_LIMIT)) ? TERM_LIMIT : r_acc[DEPTH_BITS-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= P_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            case (r_phase)
                P_IDLE: begin
                    if (i_start) begin
                        r_acc   <= '0;
                        r_mc    <= PW'(mag_dz);
                        r_mr    <= mag_run;
                        r_den   <= mag_span;
                        r_neg   <= i_dz[DEPTH_BITS-1] ^ i_run[RUN_BITS-1] ^ i_span[RUN_BITS-1];
                        r_cnt   <= CNTW'(RUN_BITS);
                        r_phase <= P_MUL;
                    end
                end
                P_MUL: begin
                    if (r_mr[0]) begin
                        r_acc <= r_acc + r_mc;
                    end
                    r_mc  <= {r_mc[PW-2:0], 1'b0};
                    r_mr  <= r_mr >> 1;
                    r_cnt <= r_cnt - CNTW'(1);
                    if (r_cnt == CNTW'(1)) begin
                        r_cnt   <= CNTW'(PW);
                        r_rem   <= '0;
                        r_phase <= P_DIV;
                    end
                end
                P_DIV: begin
                    r_rem <= fits ? RUN_BITS'(shifted - {1'b0, r_den})
                                  : shifted[RUN_BITS-1:0];
                    r_acc <= {r_acc[PW-2:0], fits};
                    r_cnt <= r_cnt - CNTW'(1);
                    if (r_cnt == CNTW'(1)) begin
                        r_phase <= P_FIN;
                    end
                end
                P_FIN: begin
                    r_term  <= r_neg ? -$signed(q_sat) : $signed(q_sat);
                    r_done  <= 1'b1;
                    r_phase <= P_IDLE;
                end
                default: begin
                    r_phase <= P_IDLE;
                end
            endcase
        end
    end

    assign o_done = r_done;
    assign o_term = r_term;

endmodule

`default_nettype wire

// File: design/segment_depth_order.sv
`timescale 1ns / 1ps
`default_nettype none

// Segments are taken one at a time while busy is low and compared with every stored
// segment in ascending order; each overlapping pair yields one result, and a segment
// arriving at a full store yields a single rejected result. Results appear for exactly
// one cycle on o_valid and cannot be held off. COORD_BITS is capped at 32. A stored
// segment that overlaps takes longer than one that does not: each such pair uses the
// bit-serial multiply and restoring divide unit up to twice, once per depth
// interpolation; the stored segments are read from one RAM, one entry per pair.
module segment_depth_order #(
    parameter int MAX_SEGMENTS = sdo_pkg::DEF_MAX_SEGMENTS,
    parameter int COORD_BITS   = sdo_pkg::DEF_COORD_BITS
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_start,
    input  wire sdo_pkg::t_item   i_item,
    output logic                  o_busy,
    output logic                  o_valid,
    output sdo_pkg::t_result      o_result
);
    import sdo_pkg::*;

    localparam int CW = (COORD_BITS < FIELD_BITS) ? COORD_BITS : FIELD_BITS;
    localparam int RB = CW + 1;
    localparam int ZW = DEPTH_BITS;
    localparam int IW = $clog2(MAX_SEGMENTS);
    localparam int NW = $clog2(MAX_SEGMENTS + 1);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_READ   = 3'd1;
    localparam logic [2:0] S_EVAL   = 3'd2;
    localparam logic [2:0] S_I1     = 3'd3;
    localparam logic [2:0] S_SETUP2 = 3'd4;
    localparam logic [2:0] S_I2     = 3'd5;
    localparam logic [2:0] S_CMP    = 3'd6;
    localparam logic [2:0] S_DONE   = 3'd7;

    logic [2:0]           r_state, n_state;
    logic [NW-1:0]        r_cnt, n_cnt;
    logic                 r_seen, n_seen;
    logic [IW-1:0]        r_j, n_j;
    logic signed [CW-1:0] r_x0, n_x0, r_z0, n_z0, r_x1, n_x1, r_z1, n_z1;
    logic signed [CW-1:0] r_xl, n_xl;
    logic                 r_left_j, n_left_j;
    logic                 r_right_j, n_right_j;
    logic signed [ZW-1:0] r_zi0, n_zi0, r_zj0, n_zj0, r_zi1, n_zi1, r_zj1, n_zj1;
    logic signed [ZW-1:0] r_ip_dz, n_ip_dz;
    logic signed [RB-1:0] r_ip_run, n_ip_run, r_ip_span, n_ip_span;
    logic                 r_ip_go, n_ip_go;
    t_result              r_pend, n_pend;
    logic                 r_pend_v, n_pend_v;
    t_result              r_out, n_out;
    logic                 r_out_v, n_out_v;

    logic [4*CW-1:0]      rd_data;
    logic                 we;
    logic signed [CW-1:0] ax, az, bx, bz;
    logic [NW-1:0]        eff_cnt;
    logic                 accept;
    logic                 ip_done;
    logic signed [ZW-1:0] ip_term;
    logic signed [RB-1:0] span;
    t_result              res;

    sdo_ram #(
        .WIDTH (4 * CW),
        .DEPTH (MAX_SEGMENTS)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (r_cnt[IW-1:0]),
        .i_wdata ({r_x0, r_z0, r_x1, r_z1}),
        .i_raddr (r_j),
        .o_rdata (rd_data)
    );

    sdo_interp #(
        .RUN_BITS (RB)
    ) u_interp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_ip_go),
        .i_dz    (r_ip_dz),
        .i_run   (r_ip_run),
        .i_span  (r_ip_span),
        .o_done  (ip_done),
        .o_term  (ip_term)
    );

    assign ax     = $signed(rd_data[4*CW-1:3*CW]);
    assign az     = $signed(rd_data[3*CW-1:2*CW]);
    assign bx     = $signed(rd_data[2*CW-1:CW]);
    assign bz     = $signed(rd_data[CW-1:0]);
    assign accept = i_start && (r_state == S_IDLE);

    always_comb begin
        n_state   = r_state;
        n_cnt     = r_cnt;
        n_seen    = r_seen;
        n_j       = r_j;
        n_x0      = r_x0;
        n_z0      = r_z0;
        n_x1      = r_x1;
        n_z1      = r_z1;
        n_xl      = r_xl;
        n_left_j  = r_left_j;
        n_right_j = r_right_j;
        n_zi0     = r_zi0;
        n_zj0     = r_zj0;
        n_zi1     = r_zi1;
        n_zj1     = r_zj1;
        n_ip_dz   = r_ip_dz;
        n_ip_run  = r_ip_run;
        n_ip_span = r_ip_span;
        n_ip_go   = 1'b0;
        n_pend    = r_pend;
        n_pend_v  = r_pend_v;
        n_out     = r_out;
        n_out_v   = 1'b0;
        we        = 1'b0;
        eff_cnt   = i_item.first_of_set ? '0 : r_cnt;
        span      = '0;
        res       = '0;

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_cnt    = eff_cnt;
                    n_seen   = i_item.first_of_set ? 1'b0 : r_seen;
                    n_x0     = CW'(i_item.left_x);
                    n_z0     = CW'(i_item.left_depth);
                    n_x1     = CW'(i_item.right_x);
                    n_z1     = CW'(i_item.right_depth);
                    n_j      = '0;
                    n_pend_v = 1'b0;
                    if (eff_cnt >= NW'(MAX_SEGMENTS)) begin
                        n_out              = '0;
                        n_out.rejected     = 1'b1;
                        n_out.any_crossing = n_seen;
                        n_out.last         = 1'b1;
                        n_out_v            = 1'b1;
                    end else if (eff_cnt == '0) begin
                        n_state = S_DONE;
                    end else begin
                        n_state = S_READ;
                    end
                end
            end
            S_READ: begin
                n_state = S_EVAL;
            end
            S_EVAL: begin
                n_zi0 = ZW'(r_z0);
                n_zj0 = ZW'(az);
                n_zi1 = ZW'(r_z1);
                n_zj1 = ZW'(bz);
                if (!(r_x1 > ax && bx > r_x0)) begin
                    n_state = S_CMP;
                end else begin
                    n_left_j = ax < r_x0;
                    if (ax < r_x0) begin
                        n_xl     = r_x0;
                        span     = RB'(bx) - RB'(ax);
                        n_ip_dz  = ZW'(bz) - ZW'(az);
                        n_ip_run = RB'(r_x0) - RB'(ax);
                    end else begin
                        n_xl     = ax;
                        span     = RB'(r_x1) - RB'(r_x0);
                        n_ip_dz  = ZW'(r_z1) - ZW'(r_z0);
                        n_ip_run = RB'(ax) - RB'(r_x0);
                    end
                    n_ip_span = span;
                    if (span == '0) begin
                        n_state = S_SETUP2;
                    end else begin
                        n_ip_go = 1'b1;
                        n_state = S_I1;
                    end
                end
            end
            S_I1: begin
                if (ip_done) begin
                    if (r_left_j) begin
                        n_zj0 = r_zj0 + ip_term;
                    end else begin
                        n_zi0 = r_zi0 + ip_term;
                    end
                    n_state = S_SETUP2;
                end
            end
            S_SETUP2: begin
                n_right_j = bx > r_x1;
                if (bx > r_x1) begin
                    span     = RB'(bx) - RB'(r_xl);
                    n_ip_dz  = ZW'(bz) - r_zj0;
                    n_ip_run = RB'(r_x1) - RB'(r_xl);
                end else begin
                    span     = RB'(r_x1) - RB'(r_xl);
                    n_ip_dz  = ZW'(r_z1) - r_zi0;
                    n_ip_run = RB'(bx) - RB'(r_xl);
                end
                n_ip_span = span;
                if (span == '0) begin
                    n_state = S_CMP;
                end else begin
                    n_ip_go = 1'b1;
                    n_state = S_I2;
                end
            end
            S_I2: begin
                if (ip_done) begin
                    if (r_right_j) begin
                        n_zj1 = r_zj0 + ip_term;
                    end else begin
                        n_zi1 = r_zi0 + ip_term;
                    end
                    n_state = S_CMP;
                end
            end
            S_CMP: begin
                if (r_x1 > ax && bx > r_x0) begin
                    if (r_zi0 >= r_zj0 && r_zi1 >= r_zj1) begin
                        res.front_index = INDEX_BITS'(r_cnt);
                        res.back_index  = INDEX_BITS'(r_j);
                    end else if (r_zi0 <= r_zj0 && r_zi1 <= r_zj1) begin
                        res.front_index = INDEX_BITS'(r_j);
                        res.back_index  = INDEX_BITS'(r_cnt);
                    end else begin
                        res.front_index = INDEX_BITS'(r_cnt);
                        res.back_index  = INDEX_BITS'(r_j);
                        res.crossed     = 1'b1;
                        n_seen          = 1'b1;
                    end
                    res.any_crossing = n_seen;
                    if (r_pend_v) begin
                        n_out   = r_pend;
                        n_out_v = 1'b1;
                    end
                    n_pend   = res;
                    n_pend_v = 1'b1;
                end
                if (NW'(r_j) + NW'(1) == r_cnt) begin
                    n_state = S_DONE;
                end else begin
                    n_j     = r_j + IW'(1);
                    n_state = S_READ;
                end
            end
            S_DONE: begin
                if (r_pend_v) begin
                    n_out      = r_pend;
                    n_out.last = 1'b1;
                    n_out_v    = 1'b1;
                end
                n_pend_v = 1'b0;
                we       = 1'b1;
                n_cnt    = r_cnt + NW'(1);
                n_state  = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_cnt    <= '0;
            r_seen   <= 1'b0;
            r_j      <= '0;
            r_ip_go  <= 1'b0;
            r_pend_v <= 1'b0;
            r_out_v  <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_cnt    <= n_cnt;
            r_seen   <= n_seen;
            r_j      <= n_j;
            r_ip_go  <= n_ip_go;
            r_pend_v <= n_pend_v;
            r_out_v  <= n_out_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_x0      <= n_x0;
        r_z0      <= n_z0;
        r_x1      <= n_x1;
        r_z1      <= n_z1;
        r_xl      <= n_xl;
        r_left_j  <= n_left_j;
        r_right_j <= n_right_j;
        r_zi0     <= n_zi0;
        r_zj0     <= n_zj0;
        r_zi1     <= n_zi1;
        r_zj1     <= n_zj1;
        r_ip_dz   <= n_ip_dz;
        r_ip_run  <= n_ip_run;
        r_ip_span <= n_ip_span;
        r_pend    <= n_pend;
        r_out     <= n_out;
    end

    assign o_busy   = (r_state != S_IDLE);
    assign o_valid  = r_out_v;
    assign o_result = r_out;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= NW'(MAX_SEGMENTS))
        else $error("stored count exceeds capacity");

    a_reject_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_result.rejected |-> o_result.last && !o_result.crossed)
        else $error("rejected result is not a lone final result");

    a_cross_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_result.crossed |-> o_result.any_crossing)
        else $error("crossing not reflected in status");

    a_pair_distinct: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_result.rejected |-> o_result.front_index != o_result.back_index)
        else $error("pair result names one segment twice");

    a_store_write_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        we |=> r_state == S_IDLE && !r_pend_v)
        else $error("store written while work remains");

endmodule

`default_nettype wire
